/* sv/ptt_pkg.sv */
// package for the periodic timer table
// holds sizes, request and status codes; no dependencies
`timescale 1ns / 1ps
package ptt_pkg;
   localparam int NUM_SLOTS = 64;
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_CREATE = 2'd1;
   localparam logic [1:0] REQ_CANCEL = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
endpackage

/* sv/periodic_timer_table.sv */
// Periodic timer table. Requests are taken one at a time: req_stall stays high from the
// accepting edge until the request is finished and its last word sits in the output
// register. A create or an unused request type goes straight to the done state. A cancel
// walks the slots in order until the id is found, skipping each inactive slot and reading
// and checking each active one. A tick walks them too: each active slot with a nonzero
// interval passes through a read, a check, a 32-step restoring remainder unit shared by all
// slots, then an emit; an active slot with a zero interval is read and checked, and an
// inactive slot is skipped. Each fired id is held back until the next one is found or the
// walk ends, so the last flag is exact; a word waiting in the output register holds up the walk.
// depends on ptt_pkg
`timescale 1ns / 1ps
module periodic_timer_table import ptt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_interval,
   input  logic        req_periodic,
   input  logic [31:0] req_cancel_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic        rsp_fired,
   output logic [31:0] rsp_uptime_now,
   output logic        rsp_last
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_READ = 6'b000010, S_CHECK = 6'b000100,
      S_DIV = 6'b001000, S_EMIT = 6'b010000, S_DONE = 6'b100000
   } state_type;

   logic [31:0] id_mem [NUM_SLOTS];
   logic [31:0] ivl_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] per_ff, act_ff;

   state_type state_ff;
   logic [1:0]  op_ff;
   logic [31:0] cid_ff, uptime_ff, next_id_ff;
   logic [CNT_W-1:0] used_ff, idx_ff;
   logic [31:0] rd_id_ff, rd_ivl_ff, rem_ff;
   logic [5:0]  bit_ff;
   logic        any_ff, found_ff;
   logic        ov_ff;
   logic [1:0]  res_status_ff;
   logic [31:0] res_id_ff;
   logic        res_fired_ff;
   logic [1:0]  o_status_ff;
   logic [31:0] o_id_ff, o_uptime_ff;
   logic        o_fired_ff, o_last_ff;

   logic [SLOT_W-1:0] idx;
   logic [32:0] rem_sh;
   logic [31:0] rem_in;
   logic        out_free;
   logic        out_load;

   assign idx = idx_ff[SLOT_W-1:0];
   assign out_free = !ov_ff || !rsp_stall;
   assign out_load = out_free && ((state_ff == S_DONE) ||
                                  (state_ff == S_EMIT && rem_ff == '0 && any_ff));
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_status = o_status_ff;
   assign rsp_result_id = o_id_ff;
   assign rsp_fired = o_fired_ff;
   assign rsp_uptime_now = o_uptime_ff;
   assign rsp_last = o_last_ff;

   // one restoring step of uptime mod interval
   assign rem_sh = {rem_ff, uptime_ff[bit_ff[4:0]]};
   assign rem_in = (rem_sh >= {1'b0, rd_ivl_ff}) ? 32'(rem_sh - {1'b0, rd_ivl_ff})
                                                : rem_sh[31:0];

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && req_type == REQ_CREATE &&
          used_ff < CNT_W'(NUM_SLOTS)) begin
         id_mem[used_ff[SLOT_W-1:0]] <= next_id_ff;
         ivl_mem[used_ff[SLOT_W-1:0]] <= req_interval;
      end
      rd_id_ff <= id_mem[idx];
      rd_ivl_ff <= ivl_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff <= '0;
         per_ff <= '0;
         used_ff <= '0;
         next_id_ff <= 32'd1;
         uptime_ff <= '0;
         ov_ff <= 1'b0;
         idx_ff <= '0;
         op_ff <= REQ_TICK;
         any_ff <= 1'b0;
         found_ff <= 1'b0;
         bit_ff <= '0;
         rem_ff <= '0;
         cid_ff <= '0;
         res_status_ff <= ST_OK;
         res_id_ff <= '0;
         res_fired_ff <= 1'b0;
         o_status_ff <= ST_OK;
         o_id_ff <= '0;
         o_uptime_ff <= '0;
         o_fired_ff <= 1'b0;
         o_last_ff <= 1'b0;
      end else begin
         if (out_load) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_type;
                  cid_ff <= req_cancel_id;
                  idx_ff <= '0;
                  any_ff <= 1'b0;
                  found_ff <= 1'b0;
                  res_fired_ff <= 1'b0;
                  case (req_type)
                     REQ_TICK: begin
                        uptime_ff <= uptime_ff + 32'd1;
                        res_status_ff <= ST_OK;
                        res_id_ff <= '0;
                        state_ff <= S_READ;
                     end
                     REQ_CREATE: begin
                        if (used_ff < CNT_W'(NUM_SLOTS)) begin
                           act_ff[used_ff[SLOT_W-1:0]] <= 1'b1;
                           per_ff[used_ff[SLOT_W-1:0]] <= req_periodic;
                           used_ff <= used_ff + CNT_W'(1);
                           next_id_ff <= next_id_ff + 32'd1;
                           res_status_ff <= ST_OK;
                           res_id_ff <= next_id_ff;
                        end else begin
                           res_status_ff <= ST_FULL;
                           res_id_ff <= '0;
                        end
                        state_ff <= S_DONE;
                     end
                     REQ_CANCEL: begin
                        res_status_ff <= ST_OK;
                        res_id_ff <= '0;
                        state_ff <= S_READ;
                     end
                     default: begin
                        res_status_ff <= ST_OK;
                        res_id_ff <= '0;
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_READ: begin
               if (idx_ff >= used_ff || found_ff) begin
                  if (op_ff == REQ_CANCEL && !found_ff) res_status_ff <= ST_NOT_FOUND;
                  state_ff <= S_DONE;
               end else if (!act_ff[idx]) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (op_ff == REQ_CANCEL) begin
                  if (rd_id_ff == cid_ff) begin
                     act_ff[idx] <= 1'b0;
                     found_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= S_READ;
               end else if (rd_ivl_ff == '0) begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= S_READ;
               end else begin
                  rem_ff <= '0;
                  bit_ff <= 6'd31;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= rem_in;
               bit_ff <= bit_ff - 6'd1;
               if (bit_ff == 6'd0) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (rem_ff != '0) begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= S_READ;
               end else if (out_free) begin
                  // send the held word and hold this one until the next or the end
                  if (any_ff) begin
                     o_status_ff <= res_status_ff;
                     o_id_ff <= res_id_ff;
                     o_fired_ff <= res_fired_ff;
                     o_uptime_ff <= uptime_ff;
                     o_last_ff <= 1'b0;
                  end
                  any_ff <= 1'b1;
                  res_status_ff <= ST_OK;
                  res_id_ff <= rd_id_ff;
                  res_fired_ff <= 1'b1;
                  if (!per_ff[idx]) act_ff[idx] <= 1'b0;
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= S_READ;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  o_status_ff <= res_status_ff;
                  o_id_ff <= res_id_ff;
                  o_fired_ff <= res_fired_ff;
                  o_uptime_ff <= uptime_ff;
                  o_last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
